[hdl/rtp_pkg.sv]
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants of the RTP reorder buffer.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int MAX_RESULTS   = 64;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [6:0] PT_RESET  = 7'd111;
  localparam logic [5:0] GAP_RESET = 6'd50;
  localparam logic [4:0] HDR_BYTES = 5'd12;

  typedef enum logic [0:0] {
    REG_PAYLOAD_TYPE = 1'b0,
    REG_MAX_GAP      = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ACT_PLAY      = 3'd0,
    ACT_QUEUE     = 3'd1,
    ACT_DROP      = 3'd2,
    ACT_IGNORE    = 3'd3,
    ACT_MALFORMED = 3'd4
  } action_t;

  typedef struct packed {
    logic [7:0]  header_byte0;
    logic [7:0]  header_byte1;
    logic [15:0] sequence_req;
    logic [15:0] extension_words;
    logic [10:0] packet_length;
    logic [7:0]  packet_handle;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] out_sequence;
    logic [7:0]  out_handle;
    logic [18:0] payload_offset;
    logic [10:0] payload_length;
    logic        last;
  } out_item_t;

  // classified packet handed from front to back; kind is PLAY for a good packet
  typedef struct packed {
    action_t     kind;
    logic [15:0] seq;
    logic [7:0]  handle;
    logic [18:0] offset;
    logic [10:0] length;
  } cls_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [18:0] offset;
    logic [10:0] length;
  } slot_t;

endpackage

[hdl/rtp_reorder_buffer.sv]
// ----------------------------------------------------------------------------
// rtp_reorder_buffer
// RTP jitter reorder buffer: releases packet descriptors in sequence order.
// ----------------------------------------------------------------------------
// Input queue: packet is transferred when push is high and full is low. The
// intake stage computes payload offset/length and checks type and length,
// then parks the packet in a two-entry queue, so up to two packets are taken
// while the sequencer is busy.
// Result queue: while empty is low the oldest result is on result; it is
// transferred when pop is high. A stalled receiver holds the result register
// and the sequencer waits; intake keeps filling its queue until full.
// Order: an ignored, malformed or dropped packet goes from the intake queue
// straight to the result register; a played or queued packet passes the hold
// register first. Each stored successor drained afterwards takes a slot RAM
// read, then a result, up to 64 results per packet.
// Config: cfg_we writes cfg_data to register cfg_index (0 payload type,
// 1 max gap); the user writes only while idle, the block does not enforce it.
// Reset (rst, synchronous) clears the queues, the started flag, the last
// played sequence and all slot valid bits; registers return to 111 and 50.
// SLOTS must be a power of two.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer #(
  parameter int SLOTS = rtp_pkg::SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rtp_pkg::in_item_t  packet,
  output logic               empty,
  input  logic               pop,
  output rtp_pkg::out_item_t result,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [6:0]         cfg_data
);
  import rtp_pkg::*;

  logic [6:0] payload_type;
  logic [5:0] max_gap;
  logic       q_valid;
  cls_t       q_entry;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_type <= PT_RESET;
      max_gap      <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAYLOAD_TYPE: payload_type <= cfg_data;
        REG_MAX_GAP:      max_gap      <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  rtp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .packet      (packet),
    .payload_type(payload_type),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop)
  );

  rtp_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .max_gap(max_gap),
    .q_valid(q_valid),
    .q_entry(q_entry),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

[hdl/rtp_ram.sv]
// ----------------------------------------------------------------------------
// rtp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/rtp_front.sv]
// ----------------------------------------------------------------------------
// rtp_front
// Packet intake: payload offset/length, type and length checks, and a
// two-entry queue toward the sequencing logic.
// ----------------------------------------------------------------------------
module rtp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rtp_pkg::in_item_t packet,
  input  logic [6:0]        payload_type,
  output logic              q_valid,
  output rtp_pkg::cls_t     q_entry,
  input  logic              q_pop
);
  import rtp_pkg::*;

  cls_t        entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  cls_t        cls;
  logic [18:0] off;
  logic [18:0] ext_bytes;
  logic        xfer_in;

  always_comb begin
    ext_bytes = {1'b0, packet.extension_words, 2'b00} + 19'd4;
    off = 19'(HDR_BYTES) + 19'({packet.header_byte0[3:0], 2'b00});
    if (packet.header_byte0[4]) begin
      off = off + ext_bytes;
    end
    cls.seq    = packet.sequence_req;
    cls.handle = packet.packet_handle;
    if (packet.header_byte1[6:0] != payload_type) begin
      cls.kind   = ACT_IGNORE;
      cls.offset = '0;
      cls.length = '0;
    end else if (off > 19'(packet.packet_length)) begin
      cls.kind   = ACT_MALFORMED;
      cls.offset = off;
      cls.length = '0;
    end else begin
      cls.kind   = ACT_PLAY;
      cls.offset = off;
      cls.length = packet.packet_length - off[10:0];
    end
  end

  assign full    = count[1];
  assign xfer_in = push && !full;
  assign q_valid = count != 2'd0;
  assign q_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (xfer_in) begin
      entries[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (xfer_in) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(xfer_in) - 2'(q_pop);
    end
  end

endmodule

[hdl/rtp_back.sv]
// ----------------------------------------------------------------------------
// rtp_back
// Sequencing: play/queue/drop decision, slot table, in-order drain walk and
// the result register.
// ----------------------------------------------------------------------------
module rtp_back #(
  parameter int SLOTS = rtp_pkg::SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [5:0]         max_gap,
  input  logic               q_valid,
  input  rtp_pkg::cls_t      q_entry,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output rtp_pkg::out_item_t result
);
  import rtp_pkg::*;

  localparam int SW = $clog2(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t          state;
  logic            started;
  logic [15:0]     last_played;
  logic [SLOTS-1:0] valid;
  logic [CNT_W-1:0] n;
  cls_t            hold;
  logic            res_valid;
  out_item_t       res;

  logic            emit_ok;
  logic            res_load;
  logic [15:0]     seq_dist;
  logic [SW-1:0]   slot;
  logic [15:0]     nxt;
  logic [SW-1:0]   nslot;
  logic            more;
  logic            go_play;
  logic            go_queue;
  logic            ram_we;
  logic            ram_re;
  slot_t           ram_wdata;
  slot_t           ram_rdata;

  // SLOTS is a power of two: the slot is the low sequence bits
  assign seq_dist = q_entry.seq - last_played;
  assign slot     = q_entry.seq[SW-1:0];
  assign nxt      = last_played + 16'd1;
  assign nslot    = nxt[SW-1:0];
  assign more     = valid[nslot] && (n < CNT_W'(MAX_RESULTS));
  assign emit_ok  = !res_valid || pop;

  assign go_play  = (q_entry.kind == ACT_PLAY) && (!started || seq_dist == 16'd1);
  assign go_queue = (q_entry.kind == ACT_PLAY) && !go_play && seq_dist != 16'd0 &&
                    seq_dist <= 16'(max_gap) && seq_dist <= 16'(SLOTS - 1) &&
                    !valid[slot];

  // result register loads on a single-result packet or on each walk step
  assign res_load = emit_ok &&
                    ((state == S_IDLE && q_valid && !go_play && !go_queue) ||
                     state == S_CHECK);

  always_comb begin
    q_pop = 1'b0;
    if (state == S_IDLE && q_valid) begin
      q_pop = go_play || go_queue || emit_ok;
    end
  end

  assign ram_we    = (state == S_IDLE) && q_valid && go_queue;
  assign ram_wdata = '{handle: q_entry.handle, offset: q_entry.offset,
                       length: q_entry.length};
  assign ram_re    = (state == S_CHECK) && emit_ok && more;

  rtp_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(nslot),
    .rdata(ram_rdata)
  );

  assign empty  = !res_valid;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      started     <= 1'b0;
      last_played <= '0;
      valid       <= '0;
      n           <= '0;
      res_valid   <= 1'b0;
    end else begin
      res_valid <= res_load || (res_valid && !pop);
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (go_play) begin
              started      <= 1'b1;
              last_played  <= q_entry.seq;
              valid[slot]  <= 1'b0;
              hold         <= q_entry;
              n            <= CNT_W'(1);
              state        <= S_CHECK;
            end else if (go_queue) begin
              valid[slot]  <= 1'b1;
              hold         <= '{kind: ACT_QUEUE, seq: q_entry.seq, handle: q_entry.handle,
                                offset: q_entry.offset, length: q_entry.length};
              n            <= CNT_W'(1);
              state        <= S_CHECK;
            end else if (emit_ok) begin
              res.action         <= (q_entry.kind == ACT_PLAY) ? ACT_DROP : q_entry.kind;
              res.out_sequence   <= q_entry.seq;
              res.out_handle     <= q_entry.handle;
              res.payload_offset <= q_entry.offset;
              res.payload_length <= q_entry.length;
              res.last           <= 1'b1;
            end
          end
        end
        S_CHECK: begin
          if (emit_ok) begin
            res.action         <= hold.kind;
            res.out_sequence   <= hold.seq;
            res.out_handle     <= hold.handle;
            res.payload_offset <= hold.offset;
            res.payload_length <= hold.length;
            res.last           <= !more;
            state              <= more ? S_READ : S_IDLE;
          end
        end
        S_READ: begin
          hold.kind    <= ACT_PLAY;
          hold.seq     <= nxt;
          hold.handle  <= ram_rdata.handle;
          hold.offset  <= ram_rdata.offset;
          hold.length  <= ram_rdata.length;
          valid[nslot] <= 1'b0;
          last_played  <= nxt;
          n            <= n + CNT_W'(1);
          state        <= S_CHECK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/rtp_checker.sv]
// ----------------------------------------------------------------------------
// rtp_checker
// Port-level checks of the reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rtp_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input rtp_pkg::out_item_t result
);
  import rtp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    !empty && (result.action == ACT_DROP || result.action == ACT_IGNORE ||
               result.action == ACT_MALFORMED) |-> result.last)
    else $error("single result without last");

  a_malformed_len: assert property (@(posedge clk) disable iff (rst)
    !empty && result.action == ACT_MALFORMED |-> result.payload_length == 11'd0)
    else $error("malformed result with nonzero length");

  a_ignore_off: assert property (@(posedge clk) disable iff (rst)
    !empty && result.action == ACT_IGNORE |-> result.payload_offset == 19'd0)
    else $error("ignored result with nonzero offset");

endmodule

bind rtp_reorder_buffer rtp_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .result(result)
);

[tb/sv/rtp_reorder_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_reorder_checker
// Watches the packet, result and register ports of the reorder buffer, keeps
// its own copy of the sequencing state, and compares every result transfer
// with the oldest expected result.
// ----------------------------------------------------------------------------
module rtp_reorder_checker
  import rtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  in_item_t   packet,
  input  logic       empty,
  input  logic       pop,
  input  out_item_t  result,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  output int         errors,
  output int         outstanding
);

  localparam int NSLOT = 64;

  logic [6:0]  accept_pt;
  logic [5:0]  store_gap;
  logic        playing;
  logic [15:0] last_seq;
  logic        held    [NSLOT];
  logic [7:0]  held_hdl[NSLOT];
  logic [18:0] held_off[NSLOT];
  logic [10:0] held_len[NSLOT];
  out_item_t   want_q[$];

  assign outstanding = want_q.size();

  function automatic out_item_t mk_res(action_t a, logic [15:0] s, logic [7:0] h,
                                       logic [18:0] o, logic [10:0] l);
    out_item_t r;
    r.action = a;
    r.out_sequence = s;
    r.out_handle = h;
    r.payload_offset = o;
    r.payload_length = l;
    r.last = 1'b0;
    return r;
  endfunction

  // sequencing of one accepted packet; appends its results to want_q
  task automatic sequence_packet(in_item_t p);
    int          off;
    int          n;
    logic [15:0] ahead;
    logic [15:0] nxt;
    logic [5:0]  slot;
    logic [10:0] len;
    out_item_t   r;
    n = 0;
    if (p.header_byte1[6:0] != accept_pt) begin
      r = mk_res(ACT_IGNORE, p.sequence_req, p.packet_handle, '0, '0);
      r.last = 1'b1;
      want_q.push_back(r);
      return;
    end
    off = 12 + 4 * int'(p.header_byte0[3:0]);
    if (p.header_byte0[4]) off += 4 * int'(p.extension_words) + 4;
    if (off > int'(p.packet_length)) begin
      r = mk_res(ACT_MALFORMED, p.sequence_req, p.packet_handle, off[18:0], '0);
      r.last = 1'b1;
      want_q.push_back(r);
      return;
    end
    len = p.packet_length - off[10:0];
    ahead = p.sequence_req - last_seq;
    slot = p.sequence_req[5:0];
    if (!playing || ahead == 16'd1) begin
      playing = 1'b1;
      last_seq = p.sequence_req;
      held[slot] = 1'b0;
      want_q.push_back(mk_res(ACT_PLAY, p.sequence_req, p.packet_handle, off[18:0], len));
    end else if (ahead != 0 && ahead <= 16'(store_gap) && !held[slot]) begin
      held[slot] = 1'b1;
      held_hdl[slot] = p.packet_handle;
      held_off[slot] = off[18:0];
      held_len[slot] = len;
      want_q.push_back(mk_res(ACT_QUEUE, p.sequence_req, p.packet_handle, off[18:0], len));
    end else begin
      r = mk_res(ACT_DROP, p.sequence_req, p.packet_handle, off[18:0], len);
      r.last = 1'b1;
      want_q.push_back(r);
      return;
    end
    n = 1;
    while (n < MAX_RESULTS) begin
      nxt = last_seq + 16'd1;
      if (!held[nxt[5:0]]) break;
      held[nxt[5:0]] = 1'b0;
      last_seq = nxt;
      want_q.push_back(mk_res(ACT_PLAY, nxt, held_hdl[nxt[5:0]], held_off[nxt[5:0]],
                              held_len[nxt[5:0]]));
      n++;
    end
    r = want_q.pop_back();
    r.last = 1'b1;
    want_q.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (rst) begin
      accept_pt = PT_RESET;
      store_gap = GAP_RESET;
      playing = 1'b0;
      last_seq = '0;
      for (int i = 0; i < NSLOT; i++) held[i] = 1'b0;
      want_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PAYLOAD_TYPE: accept_pt = cfg_data;
          REG_MAX_GAP:      store_gap = cfg_data[5:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: %p", result);
        end else begin
          w = want_q.pop_front();
          if (result !== w) begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %p, got %p", w, result);
          end
        end
      end
      if (push && !full) sequence_packet(packet);
    end
  end

endmodule

[tb/sv/rtp_reorder_buffer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_reorder_buffer_test
// Stimulus for the RTP reorder buffer: directed corner packets, then shuffled
// in-window bursts mixed with noise, across several register settings, with
// random stalls on both queues. The checker grades every result.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer_test;
  import rtp_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  in_item_t   packet = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  result;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  int         errors;
  int         outstanding;

  logic [6:0]  cur_pt;
  int          cur_gap;
  logic [15:0] next_seq;
  bit          quiet = 1'b0;
  int          pop_hold = 0;

  always #6 clk = ~clk;

  rtp_reorder_buffer dut (.*);
  rtp_reorder_checker chk (.*);

  // receiver stalls
  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (quiet || $urandom_range(0, 5) != 0) begin
      pop <= 1'b1;
    end else begin
      pop_hold <= $urandom_range(0, 13);
      pop <= 1'b0;
    end
  end

  task automatic send(in_item_t p);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push <= 1'b1;
    packet <= p;
    do @(posedge clk); while (full);
  endtask

  // well-formed packet of the current type; mostly small header extensions
  function automatic in_item_t good_pkt(logic [15:0] s);
    in_item_t p;
    int off;
    p.header_byte0 = {3'($urandom), 1'($urandom), 4'($urandom)};
    p.header_byte1 = {1'($urandom), cur_pt};
    p.sequence_req = s;
    p.extension_words = 16'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) p.extension_words[15:2] = 14'($urandom);
    off = 12 + 4 * p.header_byte0[3:0];
    if (p.header_byte0[4]) off += 4 * p.extension_words + 4;
    if (off > 2047) begin
      p.extension_words = 16'($urandom_range(0, 3));
      off = 12 + 4 * p.header_byte0[3:0] + 4 * p.extension_words + 4;
    end
    p.packet_length = 11'($urandom_range(off, 2047));
    p.packet_handle = 8'($urandom);
    return p;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [6:0] val);
    push <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all sequences ahead within k, shuffled, so the run ends in-order
  task automatic burst(int k);
    int ord[64];
    int j;
    int t;
    for (int i = 0; i < k; i++) ord[i] = i + 1;
    for (int i = k - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ord[i];
      ord[i] = ord[j];
      ord[j] = t;
    end
    for (int i = 0; i < k; i++) send(good_pkt(next_seq + 16'(ord[i])));
    next_seq += 16'(k);
  endtask

  task automatic random_part(int items);
    in_item_t p;
    int done;
    int k;
    done = 0;
    while (done < items) begin
      case ($urandom_range(0, 7))
        0: begin
          p = in_item_t'({$urandom, $urandom, 3'($urandom)});
          send(p);
          done++;
        end
        1: begin
          p = good_pkt(next_seq + 16'($urandom_range(0, 70)));
          if ($urandom_range(0, 1)) begin
            p.header_byte0[4] = 1'b1;
            p.extension_words = 16'($urandom);
            p.packet_length = 11'($urandom_range(0, 100));
          end
          send(p);
          done++;
        end
        default: begin
          k = $urandom_range(1, cur_gap < 20 ? cur_gap : 20);
          if ($urandom_range(0, 15) == 0) k = cur_gap;
          burst(k);
          done += k;
        end
      endcase
    end
  endtask

  initial begin
    in_item_t p;
    cur_pt = PT_RESET;
    cur_gap = GAP_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, starting near the sequence wrap
    next_seq = 16'hffc8;
    send(good_pkt(next_seq));                  // first packet plays
    send(good_pkt(next_seq));                  // duplicate of last played
    send(good_pkt(next_seq + 16'd3));          // queued
    send(good_pkt(next_seq + 16'd3));          // slot occupied
    send(good_pkt(next_seq + 16'd51));         // beyond the gap
    send(good_pkt(next_seq - 16'd5));          // late
    p = good_pkt(next_seq + 16'd2);
    p.header_byte1 = 8'hff;                    // wrong payload type
    send(p);
    p = good_pkt(next_seq + 16'd2);
    p.header_byte0 = 8'h1f;
    p.extension_words = 16'hffff;              // offset far past the packet
    send(p);
    p = good_pkt(next_seq + 16'd2);
    p.header_byte0 = 8'h0f;
    p.packet_length = 11'd72;                  // payload of zero bytes
    send(p);
    p = good_pkt(next_seq + 16'd4);
    p.header_byte0 = 8'h00;
    p.packet_length = 11'd2047;
    send(p);
    send(good_pkt(next_seq + 16'd1));          // plays, then drains the rest
    next_seq += 16'd4;
    random_part(55);

    cur_gap = 63;
    write_reg(REG_MAX_GAP, 7'd63);
    cur_pt = 7'd0;
    write_reg(REG_PAYLOAD_TYPE, 7'd0);
    for (int i = 63; i >= 1; i--) send(good_pkt(next_seq + 16'(i)));  // longest drain
    next_seq += 16'd63;
    random_part(55);

    cur_gap = 2;
    write_reg(REG_MAX_GAP, 7'd2);
    cur_pt = 7'd127;
    write_reg(REG_PAYLOAD_TYPE, 7'd127);
    random_part(45);

    cur_gap = $urandom_range(3, 63);
    write_reg(REG_MAX_GAP, 7'(cur_gap));
    cur_pt = 7'($urandom_range(1, 126));
    write_reg(REG_PAYLOAD_TYPE, cur_pt);
    random_part(35);
    quiet = 1'b1;
    random_part(25);

    push <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
